// ===== rtl/givens_rotation_generate_macros.svh =====
// Assertion macros shared by the Givens rotation generator RTL.
`ifndef GIVENS_ROTATION_GENERATE_MACROS_SVH
`define GIVENS_ROTATION_GENERATE_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define GRG_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent at one edge implies consequent at the same edge.
`define GRG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/grg_pkg.sv =====
// Shared types for the Givens rotation generator.
package grg_pkg;

    localparam int DATA_W = 32;
    localparam int MAG_W  = 32;
    localparam int SQ_W   = 64;

    typedef struct packed {
        logic c_neg;
        logic s_neg;
        logic zero;
    } grg_side_t;

endpackage

// ===== rtl/grg_front.sv =====
// Front end: magnitudes, squares, square sum and initial remainders.
module grg_front #(
    parameter int FRAC_BITS = 30
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [31:0]            in_a,
    input  logic signed [31:0]            in_b,
    output logic                          out_valid,
    output grg_pkg::grg_side_t            out_side,
    output logic [63:0]                   out_sum,
    output logic [66+2*FRAC_BITS-1:0]     out_rc,
    output logic [66+2*FRAC_BITS-1:0]     out_rs
);
    import grg_pkg::*;

    localparam int RW = 66 + 2 * FRAC_BITS;

    logic              a_neg;
    logic              b_neg;
    logic [MAG_W-1:0]  a_mag;
    logic [MAG_W-1:0]  b_mag;
    grg_side_t         side1_next;

    logic              v1_reg;
    grg_side_t         side1_reg;
    logic [SQ_W-1:0]   a2_reg;
    logic [SQ_W-1:0]   b2_reg;

    logic              v2_reg;
    grg_side_t         side2_reg;
    logic [SQ_W-1:0]   sum_reg;
    logic [RW-1:0]     rc_reg;
    logic [RW-1:0]     rs_reg;

    always_comb
    begin
        a_neg = in_a[31];
        b_neg = in_b[31];
        a_mag = a_neg ? (~in_a + 32'd1) : in_a;
        b_mag = b_neg ? (~in_b + 32'd1) : in_b;
        side1_next.zero  = (a_mag == '0) && (b_mag == '0);
        side1_next.c_neg = (a_mag >= b_mag) ? 1'b0 : (a_neg ^ b_neg);
        side1_next.s_neg = (a_mag >= b_mag) ? (a_neg ^ b_neg) : 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side1_next;
            a2_reg    <= SQ_W'(a_mag) * SQ_W'(a_mag);
            b2_reg    <= SQ_W'(b_mag) * SQ_W'(b_mag);
            side2_reg <= side1_reg;
            sum_reg   <= a2_reg + b2_reg;
            rc_reg    <= RW'(a2_reg) << (2 * FRAC_BITS);
            rs_reg    <= RW'(b2_reg) << (2 * FRAC_BITS);
        end
    end

    assign out_valid = v2_reg;
    assign out_side  = side2_reg;
    assign out_sum   = sum_reg;
    assign out_rc    = rc_reg;
    assign out_rs    = rs_reg;

endmodule

// ===== rtl/grg_cell.sv =====
// One cell of the quotient chain: decides one bit of both cosine and sine.
module grg_cell #(
    parameter int FRAC_BITS = 30,
    parameter int BIT_POS   = 30
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  grg_pkg::grg_side_t            in_side,
    input  logic [63:0]                   in_sum,
    input  logic [66+2*FRAC_BITS-1:0]     in_rc,
    input  logic [66+2*FRAC_BITS-1:0]     in_rs,
    input  logic [65+FRAC_BITS-1:0]       in_pc,
    input  logic [65+FRAC_BITS-1:0]       in_ps,
    input  logic [FRAC_BITS:0]            in_qc,
    input  logic [FRAC_BITS:0]            in_qs,
    output logic                          out_valid,
    output grg_pkg::grg_side_t            out_side,
    output logic [63:0]                   out_sum,
    output logic [66+2*FRAC_BITS-1:0]     out_rc,
    output logic [66+2*FRAC_BITS-1:0]     out_rs,
    output logic [65+FRAC_BITS-1:0]       out_pc,
    output logic [65+FRAC_BITS-1:0]       out_ps,
    output logic [FRAC_BITS:0]            out_qc,
    output logic [FRAC_BITS:0]            out_qs
);
    import grg_pkg::*;

    localparam int RW = 66 + 2 * FRAC_BITS;
    localparam int PW = 65 + FRAC_BITS;
    localparam int QW = FRAC_BITS + 1;

    logic [RW-1:0] sum_sq;
    logic [PW-1:0] sum_p;
    logic [RW-1:0] dc;
    logic [RW-1:0] ds;
    logic          take_c;
    logic          take_s;

    logic              v_reg;
    grg_side_t         side_reg;
    logic [SQ_W-1:0]   sum_reg;
    logic [RW-1:0]     rc_reg;
    logic [RW-1:0]     rs_reg;
    logic [PW-1:0]     pc_reg;
    logic [PW-1:0]     ps_reg;
    logic [QW-1:0]     qc_reg;
    logic [QW-1:0]     qs_reg;

    // (q + 2^k)^2 * sum - q^2 * sum = (2*q*sum + sum*2^k) * 2^k
    always_comb
    begin
        sum_sq = RW'(in_sum) << (2 * BIT_POS);
        sum_p  = PW'(in_sum) << BIT_POS;
        dc     = (RW'(in_pc) << (BIT_POS + 1)) + sum_sq;
        ds     = (RW'(in_ps) << (BIT_POS + 1)) + sum_sq;
        take_c = (in_rc >= dc);
        take_s = (in_rs >= ds);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= in_side;
            sum_reg  <= in_sum;
            rc_reg   <= take_c ? (in_rc - dc) : in_rc;
            rs_reg   <= take_s ? (in_rs - ds) : in_rs;
            pc_reg   <= take_c ? (in_pc + sum_p) : in_pc;
            ps_reg   <= take_s ? (in_ps + sum_p) : in_ps;
            qc_reg   <= take_c ? (in_qc | (QW'(1) << BIT_POS)) : in_qc;
            qs_reg   <= take_s ? (in_qs | (QW'(1) << BIT_POS)) : in_qs;
        end
    end

    assign out_valid = v_reg;
    assign out_side  = side_reg;
    assign out_sum   = sum_reg;
    assign out_rc    = rc_reg;
    assign out_rs    = rs_reg;
    assign out_pc    = pc_reg;
    assign out_ps    = ps_reg;
    assign out_qc    = qc_reg;
    assign out_qs    = qs_reg;

endmodule

// ===== rtl/givens_rotation_generate.sv =====
// Givens rotation generator top level: front end, quotient cell chain, output stage.
// An input transaction passes through the front-end registers, every cell of the chain and the output register.
// Throughput: one transaction per cycle while the output is not stalled; the chain has one cell per quotient bit.
// A stalled output holds the whole pipeline in place.
// Reset (rst_n low, asynchronous) clears all valid flags; payload is not reset.
`include "givens_rotation_generate_macros.svh"

module givens_rotation_generate #(
    parameter int FRAC_BITS = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] in_a,
    input  logic signed [31:0] in_b,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] cos_out,
    output logic signed [31:0] sin_out
);
    import grg_pkg::*;

    localparam int RW = 66 + 2 * FRAC_BITS;
    localparam int PW = 65 + FRAC_BITS;
    localparam int QW = FRAC_BITS + 1;
    localparam int NC = FRAC_BITS + 1;
    localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;

    logic              en;
    logic              ch_valid [NC+1];
    grg_side_t         ch_side  [NC+1];
    logic [SQ_W-1:0]   ch_sum   [NC+1];
    logic [RW-1:0]     ch_rc    [NC+1];
    logic [RW-1:0]     ch_rs    [NC+1];
    logic [PW-1:0]     ch_pc    [NC+1];
    logic [PW-1:0]     ch_ps    [NC+1];
    logic [QW-1:0]     ch_qc    [NC+1];
    logic [QW-1:0]     ch_qs    [NC+1];

    logic              ov_reg;
    logic [31:0]       cos_reg;
    logic [31:0]       sin_reg;
    logic              zero_reg;
    logic [31:0]       cos_next;
    logic [31:0]       sin_next;

    assign en       = !(ov_reg && out_stall);
    assign in_stall = !en;

    grg_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_a      (in_a),
        .in_b      (in_b),
        .out_valid (ch_valid[0]),
        .out_side  (ch_side[0]),
        .out_sum   (ch_sum[0]),
        .out_rc    (ch_rc[0]),
        .out_rs    (ch_rs[0])
    );

    assign ch_pc[0] = '0;
    assign ch_ps[0] = '0;
    assign ch_qc[0] = '0;
    assign ch_qs[0] = '0;

    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        grg_cell #(.FRAC_BITS(FRAC_BITS), .BIT_POS(FRAC_BITS - i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (ch_valid[i]),
            .in_side   (ch_side[i]),
            .in_sum    (ch_sum[i]),
            .in_rc     (ch_rc[i]),
            .in_rs     (ch_rs[i]),
            .in_pc     (ch_pc[i]),
            .in_ps     (ch_ps[i]),
            .in_qc     (ch_qc[i]),
            .in_qs     (ch_qs[i]),
            .out_valid (ch_valid[i+1]),
            .out_side  (ch_side[i+1]),
            .out_sum   (ch_sum[i+1]),
            .out_rc    (ch_rc[i+1]),
            .out_rs    (ch_rs[i+1]),
            .out_pc    (ch_pc[i+1]),
            .out_ps    (ch_ps[i+1]),
            .out_qc    (ch_qc[i+1]),
            .out_qs    (ch_qs[i+1])
        );
    end

    always_comb
    begin
        if (ch_side[NC].zero)
        begin
            cos_next = 32'(1) << FRAC_BITS;
            sin_next = '0;
        end
        else
        begin
            cos_next = ch_side[NC].c_neg ? (32'd0 - 32'(ch_qc[NC])) : 32'(ch_qc[NC]);
            sin_next = ch_side[NC].s_neg ? (32'd0 - 32'(ch_qs[NC])) : 32'(ch_qs[NC]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= ch_valid[NC];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg  <= cos_next;
            sin_reg  <= sin_next;
            zero_reg <= ch_side[NC].zero;
        end
    end

    assign out_valid = ov_reg;
    assign cos_out   = cos_reg;
    assign sin_out   = sin_reg;

    `GRG_ASSERT_IMP(a_stall_src, in_stall, out_valid && out_stall)
    `GRG_ASSERT_IMP(a_zero_out, out_valid && zero_reg, (cos_out == Q_ONE) && (sin_out == '0))
    `GRG_ASSERT_IMP(a_cos_rng, out_valid, (cos_out <= Q_ONE) && (cos_out >= -Q_ONE))
    `GRG_ASSERT_IMP(a_sin_rng, out_valid, (sin_out <= Q_ONE) && (sin_out >= -Q_ONE))

endmodule

// ===== dv/grg_checker.sv =====
// Checker for the Givens rotation generator: predicts cosine/sine per transaction and compares.
`timescale 1ns / 100ps

module grg_checker #(
    parameter int FRAC_BITS = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] in_a,
    input  logic signed [31:0] in_b,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] cos_out,
    input  logic signed [31:0] sin_out,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic signed [31:0] cs;
        logic signed [31:0] sn;
    } rot_t;

    rot_t rot_q[$];

    assign pending = rot_q.size();

    function automatic logic [63:0] ratio_mag(logic [63:0] num, logic [63:0] sum);
        logic [127:0] target;
        logic [127:0] prod;
        logic [127:0] cand;
        logic [127:0] q;
        target = 128'(num) * 128'(num);
        target = target << (2 * FRAC_BITS);
        q = 0;
        for (int bit_i = FRAC_BITS; bit_i >= 0; bit_i--)
        begin
            cand = q | (128'd1 << bit_i);
            prod = cand * cand * 128'(sum);
            if (prod <= target)
                q = cand;
        end
        return q[63:0];
    endfunction

    function automatic rot_t rotation(logic signed [31:0] a, logic signed [31:0] b);
        rot_t r;
        logic a_neg, b_neg, r_neg;
        logic [63:0] a_mag, b_mag, sum, qc, qs;
        a_neg = a[31];
        b_neg = b[31];
        a_mag = a_neg ? 64'(-65'(a)) : 64'(a);
        b_mag = b_neg ? 64'(-65'(b)) : 64'(b);
        if (a_mag == 0 && b_mag == 0)
        begin
            r.cs = 32'sd1 << FRAC_BITS;
            r.sn = 0;
            return r;
        end
        sum = a_mag * a_mag + b_mag * b_mag;
        r_neg = (a_mag >= b_mag) ? a_neg : b_neg;
        qc = ratio_mag(a_mag, sum);
        qs = ratio_mag(b_mag, sum);
        r.cs = (a_neg != r_neg) ? -qc[31:0] : qc[31:0];
        r.sn = (b_neg != r_neg) ? -qs[31:0] : qs[31:0];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        errors++;
    endtask

    always @(posedge clk)
    begin
        rot_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                rot_q.push_back(rotation(in_a, in_b));
            if (out_valid && !out_stall)
            begin
                if (rot_q.size() == 0)
                    report("unexpected transaction", cos_out, 32'hx);
                else
                begin
                    want = rot_q.pop_front();
                    if (cos_out !== want.cs)
                        report("cos_out", cos_out, want.cs);
                    if (sin_out !== want.sn)
                        report("sin_out", sin_out, want.sn);
                end
            end
        end
    end

endmodule

// ===== dv/givens_rotation_generate_tb.sv =====
// Testbench top for the Givens rotation generator: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module givens_rotation_generate_tb;

    localparam int FRAC_BITS = 30;
    localparam int LATENCY   = FRAC_BITS + 4;
    localparam int N_RANDOM  = 1400;
    localparam int MAX_CYC   = 400000;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic signed [31:0] in_a = 0;
    logic signed [31:0] in_b = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic signed [31:0] cos_out;
    logic signed [31:0] sin_out;
    int                 errors;
    int                 pending;
    int                 cyc = 0;

    always #2 clk = ~clk;

    givens_rotation_generate #(.FRAC_BITS(FRAC_BITS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_a(in_a), .in_b(in_b),
        .out_valid(out_valid), .out_stall(out_stall),
        .cos_out(cos_out), .sin_out(sin_out)
    );

    grg_checker #(.FRAC_BITS(FRAC_BITS)) u_chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_a(in_a), .in_b(in_b),
        .out_valid(out_valid), .out_stall(out_stall),
        .cos_out(cos_out), .sin_out(sin_out),
        .errors(errors), .pending(pending)
    );

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > MAX_CYC)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: long hold-off once, otherwise four stall patterns taken in turn
    always @(posedge clk)
    begin
        int mode;
        mode = (cyc / 256) % 4;
        if (cyc >= 600 && cyc < 900)
            out_stall <= 1'b1;
        else if (mode == 0)
            out_stall <= 1'b0;
        else if (mode == 1)
            out_stall <= ($urandom_range(0, 9) < 3);
        else if (mode == 2)
            out_stall <= ($urandom_range(0, 9) < 7);
        else
            out_stall <= ((cyc % 8) < 2);
    end

    // called just after a rising edge; returns just after the edge that takes the transaction
    task automatic send(logic signed [31:0] a, logic signed [31:0] b);
        in_valid <= 1'b1;
        in_a <= a;
        in_b <= b;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic idle_gap(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_val(int kind);
        logic [31:0] v;
        case (kind)
            0: v = $urandom;
            1: v = $urandom_range(0, 65535) - 32768;
            2: v = 32'sd1 << $urandom_range(0, 30);
            3: v = $urandom_range(0, 3) == 0 ? 32'h80000000 : 32'h7fffffff;
            default: v = 0;
        endcase
        return v;
    endfunction

    initial
    begin
        logic signed [31:0] da[$];
        logic signed [31:0] db[$];
        logic signed [31:0] a, b;
        int burst;
        int sent;
        da = '{0, 5, -5, 0, 0, 32'h80000000, 32'h7fffffff, 32'h80000000, 0,
               32'h80000000, 32'h7fffffff, 1, -1, 1, -1, 3, -3, 1, 32'h7fffffff,
               65536, -65536, 32'h80000000};
        db = '{0, 0, 0, 7, -7, 32'h80000000, 32'h7fffffff, 0, 32'h80000000,
               32'h7fffffff, 32'h80000000, 1, 1, -1, -1, 4, 4, 32'h7fffffff, -1,
               -65536, 65536, 32'h80000001};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        foreach (da[i])
        begin
            send(da[i], db[i]);
            if ($urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 3));
        end
        sent = 0;
        while (sent < N_RANDOM)
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++)
            begin
                a = rand_val($urandom_range(0, 4));
                case ($urandom_range(0, 7))
                    0: b = a;
                    1: b = -a;
                    2: b = 0;
                    default: b = rand_val($urandom_range(0, 4));
                endcase
                if ($urandom_range(0, 1))
                    send(a, b);
                else
                    send(b, a);
                sent++;
                if (sent == 700)
                begin
                    in_valid <= 1'b0;
                    while (pending != 0)
                        @(posedge clk);
                    @(posedge clk);
                end
            end
            idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
        end
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/grg_pkg.sv
rtl/grg_front.sv
rtl/grg_cell.sv
rtl/givens_rotation_generate.sv
dv/grg_checker.sv
dv/givens_rotation_generate_tb.sv
